>>> hdl/spirtc_pkg.sv
// Package: constants, types and helper functions for the SPI RTC register slave.
package spirtc_pkg;

    localparam int ClockRegCount = 18;
    localparam int UserSize      = 96;

    localparam logic [7:0] CLOCK_REG_END   = 8'h12;
    localparam logic [7:0] CLOCK_WINDOW    = 8'h20;
    localparam logic [7:0] USER_END        = 8'h80;
    localparam logic [7:0] WRITE_FLAG      = 8'h80;
    localparam logic [7:0] CLOCK_WRITE_END = 8'h92;
    localparam logic [7:0] USER_WRITE_BASE = 8'hA0;
    localparam logic [7:0] READ_PAST_END   = 8'hFF;
    localparam logic [7:0] HOUR_12_FLAG    = 8'h40;
    localparam logic [7:0] PM_FLAG         = 8'h20;

    localparam logic [4:0] PHASE_DATA  = 5'd8;
    localparam logic [4:0] PHASE_BYTE  = 5'd16;

    localparam int HOUR_REG    = 2;
    localparam int WEEKDAY_REG = 3;

    typedef logic [7:0] byte_t;
    typedef byte_t clock_regs_t [ClockRegCount];

    // Per-register write mask for the clock window.
    function automatic byte_t write_mask(input logic [4:0] idx);
        byte_t m;
        case (idx)
            5'd0, 5'd1, 5'd2:  m = 8'h7F;
            5'd3:              m = 8'h0F;
            5'd4, 5'd5:        m = 8'h3F;
            5'd10, 5'd14:      m = 8'h8F;
            5'd15:             m = 8'h87;
            5'd16:             m = 8'h00;
            default:           m = 8'hFF;
        endcase
        return m;
    endfunction

    // Binary to BCD, tens * 16 + units, for values below 128.
    function automatic byte_t bin_to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'd10;
        return byte_t'({tens, 4'b0000}) + byte_t'(units);
    endfunction

    // Address increment with wrap inside the clock and user windows.
    function automatic byte_t advance_address(input byte_t a);
        byte_t n;
        n = a + 8'd1;
        if (n[6:0] == 7'h20) begin
            n = n - 8'h20;
        end else if (n[6:0] == 7'h00) begin
            n = n - 8'h60;
        end
        return n;
    endfunction

endpackage

>>> hdl/spi_rtc_register_slave_top.sv
// SPI slave real-time-clock register file, one pin sample per request.
//
// Input requests (s_axis_*) carry one sample of chip enable, serial clock
// and serial data in, plus the current binary calendar time. Each request
// yields exactly one result request (m_axis_*) holding the serial data out
// level after that sample; it idles high while deselected.
// A request is taken every cycle while the skid stage is empty; its result
// goes to the output register, or to the skid stage on a stall. Throughput is
// one request per cycle, limited by the single register update per sample.
// A read of a user location is issued to the 96-byte RAM when the address is
// latched or a byte completes; the registered read data is picked up by the
// next request, before any bit can be shifted out.
// When the receiver stalls, one result waits in the output register and one
// more in a skid stage; s_axis_tready drops only when both are full.
// Reset (aresetn low, synchronous) clears the serial state, the clock
// registers and the user RAM valid bits, so the RAM reads zero until written.
module spi_rtc_register_slave_top
    import spirtc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] chip_enable, [1] serial_clock, [2] serial_data_in, [8:3] now_seconds,
    // [14:9] now_minutes, [19:15] now_hours, [22:20] now_weekday,
    // [27:23] now_day_of_month, [31:28] now_month, [38:32] now_year, [39] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] serial_data_out, [7:1] zero
    output logic [7:0]  m_axis_tdata
);

    logic       chip_enable, serial_clock, serial_data_in;
    logic [5:0] now_seconds, now_minutes;
    logic [4:0] now_hours, now_day_of_month;
    logic [2:0] now_weekday;
    logic [3:0] now_month;
    logic [6:0] now_year;

    assign chip_enable      = s_axis_tdata[0];
    assign serial_clock     = s_axis_tdata[1];
    assign serial_data_in   = s_axis_tdata[2];
    assign now_seconds      = s_axis_tdata[8:3];
    assign now_minutes      = s_axis_tdata[14:9];
    assign now_hours        = s_axis_tdata[19:15];
    assign now_weekday      = s_axis_tdata[22:20];
    assign now_day_of_month = s_axis_tdata[27:23];
    assign now_month        = s_axis_tdata[31:28];
    assign now_year         = s_axis_tdata[38:32];

    logic [4:0]  bit_phase_reg, bit_phase_next;
    byte_t       address_reg, address_next;
    byte_t       shift_byte_reg, shift_byte_next;
    logic        data_out_reg, data_out_next;
    logic        selected_reg, selected_next;
    logic        last_clock_reg, last_clock_next;
    logic        idle_clock_reg, idle_clock_next;
    clock_regs_t clock_regs_reg, clock_regs_next;
    logic        pending_reg, pending_next;

    byte_t             user_ram [UserSize];
    logic [UserSize-1:0] user_valid_reg;
    byte_t             ram_q_reg;
    logic              ram_valid_q_reg;
    logic              rd_en, wr_en;
    logic [6:0]        rd_idx, wr_idx;

    logic out_valid_reg, out_data_reg, skid_valid_reg, skid_data_reg;
    logic accept, take;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg};

    // Clock registers as freshly loaded from the current time.
    clock_regs_t time_regs;
    logic [4:0]  hour12;

    always_comb begin
        time_regs = clock_regs_reg;
        time_regs[0] = bin_to_bcd(7'(now_seconds));
        time_regs[1] = bin_to_bcd(7'(now_minutes));
        if (clock_regs_reg[HOUR_REG][6]) begin
            hour12 = (now_hours >= 5'd12) ? now_hours - 5'd12 : now_hours;
            if (hour12 == 5'd0) begin
                hour12 = 5'd12;
            end
            time_regs[HOUR_REG] = HOUR_12_FLAG | ((now_hours >= 5'd12) ? PM_FLAG : 8'h00)
                                | bin_to_bcd(7'(hour12));
        end else begin
            hour12 = now_hours;
            time_regs[HOUR_REG] = bin_to_bcd(7'(now_hours));
        end
        time_regs[WEEKDAY_REG] = byte_t'(now_weekday) + 8'd1;
        time_regs[4] = bin_to_bcd(7'(now_day_of_month));
        time_regs[5] = bin_to_bcd(7'(now_month));
        time_regs[6] = bin_to_bcd(now_year);
    end

    always_comb begin
        logic  do_load, do_time, do_store;
        byte_t ld_addr, clk_val, new_addr;
        do_load  = 1'b0;
        do_time  = 1'b0;
        do_store = 1'b0;
        clk_val  = 8'h00;
        new_addr = 8'h00;

        bit_phase_next  = bit_phase_reg;
        address_next    = address_reg;
        shift_byte_next = pending_reg ? (ram_valid_q_reg ? ram_q_reg : 8'h00)
                                      : shift_byte_reg;
        data_out_next   = data_out_reg;
        selected_next   = selected_reg;
        last_clock_next = last_clock_reg;
        idle_clock_next = idle_clock_reg;
        clock_regs_next = clock_regs_reg;
        pending_next    = 1'b0;
        rd_en  = 1'b0;
        wr_en  = 1'b0;
        rd_idx = 7'd0;
        wr_idx = 7'd0;

        if (chip_enable != selected_reg) begin
            selected_next = chip_enable;
            if (!chip_enable) begin
                bit_phase_next = 5'd0;
                data_out_next  = 1'b1;
            end else begin
                last_clock_next = serial_clock;
                idle_clock_next = serial_clock;
            end
        end

        if (selected_next && last_clock_next != serial_clock) begin
            last_clock_next = serial_clock;
            if (serial_clock != idle_clock_next) begin
                if (bit_phase_next >= PHASE_DATA && address_next < WRITE_FLAG) begin
                    data_out_next   = shift_byte_next[7];
                    shift_byte_next = {shift_byte_next[6:0], 1'b0};
                    bit_phase_next  = bit_phase_next + 5'd1;
                    if (bit_phase_next >= PHASE_BYTE) begin
                        bit_phase_next = PHASE_DATA;
                        do_load = 1'b1;
                    end
                end
            end else if (bit_phase_next < PHASE_DATA) begin
                address_next   = {address_next[6:0], serial_data_in};
                bit_phase_next = bit_phase_next + 5'd1;
                if (bit_phase_next == PHASE_DATA && address_next < WRITE_FLAG) begin
                    do_time = address_next < CLOCK_WINDOW;
                    do_load = 1'b1;
                end
            end else if (address_next >= WRITE_FLAG) begin
                shift_byte_next = {shift_byte_next[6:0], serial_data_in};
                bit_phase_next  = bit_phase_next + 5'd1;
                if (bit_phase_next >= PHASE_BYTE) begin
                    bit_phase_next = PHASE_DATA;
                    do_store = 1'b1;
                end
            end
        end

        ld_addr = address_next;
        if (do_time) begin
            clock_regs_next = time_regs;
        end
        if (ld_addr < CLOCK_REG_END) begin
            clk_val = clock_regs_next[ld_addr[4:0]];
        end

        if (do_load) begin
            if (ld_addr < CLOCK_REG_END) begin
                shift_byte_next = clk_val;
            end else if (ld_addr < CLOCK_WINDOW) begin
                shift_byte_next = 8'h00;
            end else if (ld_addr < USER_END) begin
                new_addr     = ld_addr - CLOCK_WINDOW;
                rd_idx       = new_addr[6:0];
                rd_en        = accept;
                pending_next = 1'b1;
            end else begin
                shift_byte_next = READ_PAST_END;
            end
        end

        if (do_store) begin
            if (ld_addr >= WRITE_FLAG && ld_addr < CLOCK_WRITE_END) begin
                new_addr = ld_addr - WRITE_FLAG;
                clock_regs_next[new_addr[4:0]] = shift_byte_next & write_mask(new_addr[4:0]);
            end else if (ld_addr >= USER_WRITE_BASE) begin
                new_addr = ld_addr - USER_WRITE_BASE;
                wr_idx   = new_addr[6:0];
                wr_en    = accept;
            end
        end

        if (do_load || do_store) begin
            address_next = advance_address(ld_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            user_ram[wr_idx] <= shift_byte_next;
        end
        if (rd_en) begin
            ram_q_reg <= user_ram[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_phase_reg   <= 5'd0;
            address_reg     <= 8'h00;
            shift_byte_reg  <= 8'h00;
            data_out_reg    <= 1'b1;
            selected_reg    <= 1'b0;
            last_clock_reg  <= 1'b0;
            idle_clock_reg  <= 1'b0;
            pending_reg     <= 1'b0;
            ram_valid_q_reg <= 1'b0;
            user_valid_reg  <= '0;
            for (int i = 0; i < ClockRegCount; i++) begin
                clock_regs_reg[i] <= 8'h00;
            end
        end else if (accept) begin
            bit_phase_reg   <= bit_phase_next;
            address_reg     <= address_next;
            shift_byte_reg  <= shift_byte_next;
            data_out_reg    <= data_out_next;
            selected_reg    <= selected_next;
            last_clock_reg  <= last_clock_next;
            idle_clock_reg  <= idle_clock_next;
            pending_reg     <= pending_next;
            clock_regs_reg  <= clock_regs_next;
            if (rd_en) begin
                ram_valid_q_reg <= user_valid_reg[rd_idx];
            end
            if (wr_en) begin
                user_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // Output register plus skid stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_data_reg <= data_out_next;
            end else begin
                skid_data_reg <= data_out_next;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_phase_reg < PHASE_BYTE)
        else $error("bit phase out of range");

    a_idle_high: assert property (@(posedge aclk) disable iff (!aresetn)
        !selected_reg |-> data_out_reg)
        else $error("data out not high while deselected");

    a_pending_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> (selected_reg && bit_phase_reg == PHASE_DATA))
        else $error("user RAM read pending outside a data phase");

endmodule
